>>> rtl/ifq_pkg.sv
`timescale 1ns / 1ps

package ifq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_TAKE    = 3'd1,
        OP_READ    = 3'd2,
        OP_DELETE  = 3'd3,
        OP_REVERSE = 3'd4,
        OP_CLEAR   = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DATA,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FRONT_RD,
        S_BACK_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] data;
        logic [CNT_W-1:0]   count;
        logic               is_empty;
        logic [VALUE_W-1:0] front_word;
        logic [VALUE_W-1:0] back_word;
    } t_res;

endpackage

>>> rtl/indexed_fifo_queue.sv
`timescale 1ns / 1ps

// channel  | ports                 | handshake
// request  | i_req (t_req)         | start high while busy low
// result   | o_res (t_res)         | o_done high for one cycle, no back-pressure
//
// Entries sit in a circular buffer with a head index and a direction bit.
// Append, reverse, clear, unused opcodes and any error pass through S_EXEC, S_FRONT_RD,
// S_BACK_RD and S_EMIT; take and read add S_DATA after S_EXEC; delete at position p
// moves the count - p entries behind it, one RAM read and one RAM write per moved entry.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
// busy stays high from accept through the o_done cycle.

module indexed_fifo_queue
    import ifq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state                r_state;
    t_state                n_state;
    logic [AW-1:0]         r_head;
    logic                  r_dir;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_k;
    logic [OP_W-1:0]       r_op;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    t_status               r_status;
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] r_front;

    t_status               req_status;
    logic                  cnt_zero;
    logic                  pos_bad;
    logic [CW-1:0]         k_plus;
    logic                  k_last;
    logic [AW-1:0]         map_lidx;
    logic [AW-1:0]         map_phys;
    logic                  ram_we;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    ifq_map #(
        .DEPTH(DEPTH)
    ) u_map (
        .i_head(r_head),
        .i_dir (r_dir),
        .i_lidx(map_lidx),
        .o_phys(map_phys)
    );

    ifq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(map_phys),
        .i_wdata(ram_wdata),
        .i_raddr(map_phys),
        .o_rdata(ram_rdata)
    );

    assign cnt_zero = (r_count == '0);
    assign pos_bad  = (i_req.position == '0) || (PW'(i_req.position) > PW'(r_count));
    assign k_plus   = CW'(r_k) + CW'(1);
    assign k_last   = (k_plus >= r_count);

    always_comb begin
        unique case (i_req.opcode)
            OP_APPEND:  req_status = (r_count == CW'(DEPTH)) ? ST_FULL : ST_OK;
            OP_TAKE:    req_status = cnt_zero ? ST_EMPTY : ST_OK;
            OP_READ:    req_status = pos_bad ? ST_RANGE : ST_OK;
            OP_DELETE:  req_status = cnt_zero ? ST_EMPTY : (pos_bad ? ST_RANGE : ST_OK);
            OP_REVERSE: req_status = cnt_zero ? ST_EMPTY : ST_OK;
            default:    req_status = ST_OK;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_status != ST_OK) begin
                    n_state = S_FRONT_RD;
                end else if (r_op == OP_TAKE || r_op == OP_READ) begin
                    n_state = S_DATA;
                end else if (r_op == OP_DELETE) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_FRONT_RD;
                end
            end
            S_DATA:     n_state = S_FRONT_RD;
            S_SHIFT_RD: n_state = k_last ? S_FRONT_RD : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_FRONT_RD: n_state = S_BACK_RD;
            S_BACK_RD:  n_state = S_EMIT;
            S_EMIT:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        map_lidx  = '0;
        ram_we    = 1'b0;
        ram_wdata = r_val;
        unique case (r_state)
            S_EXEC: begin
                unique case (r_op)
                    OP_APPEND: begin
                        map_lidx = AW'(r_count);
                        ram_we   = (r_status == ST_OK);
                    end
                    OP_READ:    map_lidx = AW'(r_pos - POS_W'(1));
                    OP_REVERSE: map_lidx = AW'(r_count - CW'(1));
                    default:    map_lidx = '0;
                endcase
            end
            S_DATA:     map_lidx = AW'(1);
            S_SHIFT_RD: map_lidx = AW'(k_plus);
            S_SHIFT_WR: begin
                map_lidx  = r_k;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_BACK_RD:  map_lidx = AW'(r_count - CW'(1));
            default:    map_lidx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_dir   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_req.opcode;
                        r_pos    <= i_req.position;
                        r_val    <= DATA_WIDTH'(i_req.value);
                        r_status <= req_status;
                        r_data   <= '0;
                    end
                end
                S_EXEC: begin
                    if (r_status == ST_OK) begin
                        unique case (r_op)
                            OP_APPEND: r_count <= r_count + CW'(1);
                            OP_DELETE: r_k <= AW'(r_pos - POS_W'(1));
                            OP_REVERSE: begin
                                r_head <= map_phys;
                                r_dir  <= ~r_dir;
                            end
                            OP_CLEAR: r_count <= '0;
                            default: ;
                        endcase
                    end
                end
                S_DATA: begin
                    r_data <= ram_rdata;
                    if (r_op == OP_TAKE) begin
                        r_head  <= map_phys;
                        r_count <= r_count - CW'(1);
                    end
                end
                S_SHIFT_RD: begin
                    if (k_last) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                S_SHIFT_WR: r_k <= r_k + AW'(1);
                S_BACK_RD:  r_front <= ram_rdata;
                default: ;
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_EMIT);

    always_comb begin
        o_res.status     = r_status;
        o_res.data       = VALUE_W'(r_data);
        o_res.count      = CNT_W'(r_count);
        o_res.is_empty   = cnt_zero;
        o_res.front_word = cnt_zero ? '0 : VALUE_W'(r_front);
        o_res.back_word  = cnt_zero ? '0 : VALUE_W'(ram_rdata);
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe not a single pulse");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy && !o_done)
        else $error("request accepted without going busy");

    a_error_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_status != ST_OK) |=> $stable(r_count) && $stable(r_head))
        else $error("failed request changed queue state");

endmodule

>>> rtl/ifq_ram.sv
`timescale 1ns / 1ps

module ifq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ifq_map.sv
`timescale 1ns / 1ps

module ifq_map #(
    parameter int DEPTH = 16
) (
    input  logic [$clog2(DEPTH)-1:0] i_head,
    input  logic                     i_dir,
    input  logic [$clog2(DEPTH)-1:0] i_lidx,
    output logic [$clog2(DEPTH)-1:0] o_phys
);

    localparam int AW = $clog2(DEPTH);

    logic [AW:0] head_x;
    logic [AW:0] lidx_x;
    logic [AW:0] sum;
    logic [AW:0] fwd;
    logic [AW:0] bwd;

    assign head_x = {1'b0, i_head};
    assign lidx_x = {1'b0, i_lidx};
    assign sum    = head_x + lidx_x;
    assign fwd    = (sum >= (AW+1)'(DEPTH)) ? sum - (AW+1)'(DEPTH) : sum;
    assign bwd    = (head_x >= lidx_x) ? head_x - lidx_x
                                       : head_x + (AW+1)'(DEPTH) - lidx_x;
    assign o_phys = i_dir ? bwd[AW-1:0] : fwd[AW-1:0];

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import ifq_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam logic [31:0]     ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0]     FILL_BASE  = 32'h1000_0000;
    localparam int              RANDOM_REQS = 2000;
    localparam int              WATCHDOG    = 2000;
    localparam int              TAIL_CYCLES = 2 * DEPTH_DEF + 8;
    localparam int              REQ_W       = $bits(t_req);

    typedef struct {
        t_req req;
        int   reps;
        bit   pinned;
        t_res want;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_res o_res;

    logic [31:0] shadow_words [DEPTH_DEF];
    int          shadow_count;
    int          deepest;
    t_res        pending_res [$];
    t_res        predicted;
    bit          pin_flag;
    t_res        pin_want;
    int          mismatches;
    int          accepted;
    int          results_seen;
    int          quiet;
    int          burst_left;
    int          status_tally [4];

    indexed_fifo_queue dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic t_res queue_apply(t_req req);
        t_res        r;
        logic [31:0] tmp;
        int          k;
        int          lo;
        int          hi;
        r = '0;
        r.status = ST_OK;
        case (req.opcode)
            OP_APPEND: begin
                if (shadow_count >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_count] = req.value;
                    shadow_count++;
                end
            end
            OP_TAKE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = shadow_words[0];
                    for (k = 1; k < shadow_count; k++) shadow_words[k-1] = shadow_words[k];
                    shadow_count--;
                end
            end
            OP_READ: begin
                if (req.position == 0 || req.position > shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data = shadow_words[req.position - 1];
                end
            end
            OP_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (req.position == 0 || req.position > shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = req.position; k < shadow_count; k++) begin
                        shadow_words[k-1] = shadow_words[k];
                    end
                    shadow_count--;
                end
            end
            OP_REVERSE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    lo = 0;
                    hi = shadow_count - 1;
                    while (lo < hi) begin
                        tmp = shadow_words[lo];
                        shadow_words[lo] = shadow_words[hi];
                        shadow_words[hi] = tmp;
                        lo++;
                        hi--;
                    end
                end
            end
            OP_CLEAR: shadow_count = 0;
            default: ;
        endcase
        r.count    = CNT_W'(shadow_count);
        r.is_empty = (shadow_count == 0);
        if (shadow_count > 0) begin
            r.front_word = shadow_words[0];
            r.back_word  = shadow_words[shadow_count-1];
        end
        return r;
    endfunction

    task automatic check_result(t_res got, t_res want);
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            mismatches++;
        end
        if (got.data !== want.data) begin
            $display("%0t: data expected %h got %h", $time, want.data, got.data);
            mismatches++;
        end
        if (got.count !== want.count) begin
            $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
            mismatches++;
        end
        if (got.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %b got %b", $time, want.is_empty, got.is_empty);
            mismatches++;
        end
        if (got.front_word !== want.front_word) begin
            $display("%0t: front_word expected %h got %h", $time, want.front_word,
                     got.front_word);
            mismatches++;
        end
        if (got.back_word !== want.back_word) begin
            $display("%0t: back_word expected %h got %h", $time, want.back_word,
                     got.back_word);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                results_seen++;
                if (pending_res.size() == 0) begin
                    $display("%0t: unexpected result, status %0d data %h", $time,
                             o_res.status, o_res.data);
                    mismatches++;
                end else begin
                    check_result(o_res, pending_res.pop_front());
                end
            end
            if (start && !busy) begin
                predicted = queue_apply(i_req);
                if (pin_flag) predicted = pin_want;
                status_tally[predicted.status]++;
                if (shadow_count > deepest) deepest = shadow_count;
                pending_res.push_back(predicted);
                accepted++;
            end
            if (o_done || (start && !busy)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    function automatic t_plan_row make_row(logic [OP_W-1:0] op, logic [31:0] value,
                                           logic [POS_W-1:0] pos, int reps, bit pinned,
                                           t_status st, logic [31:0] d, int cnt,
                                           logic [31:0] fw, logic [31:0] bw);
        t_plan_row row;
        row.req.opcode       = op;
        row.req.value        = value;
        row.req.position     = pos;
        row.reps             = reps;
        row.pinned           = pinned;
        row.want.status      = st;
        row.want.data        = d;
        row.want.count       = CNT_W'(cnt);
        row.want.is_empty    = (cnt == 0);
        row.want.front_word  = fw;
        row.want.back_word   = bw;
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst_left = 40;
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic issue(t_req req, bit pinned, t_res want);
        @(negedge i_clk);
        start    <= 1'b1;
        i_req    <= req;
        pin_flag  = pinned;
        pin_want  = want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= REQ_W'({$urandom, $urandom});
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_plan_row plan [$];
        t_plan_row row;
        t_req      req;
        t_res      none;
        int        fill_bias;
        int        r;

        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_req    = '0;
        pin_flag = 1'b0;
        pin_want = '0;
        none     = '0;
        shadow_count = 0;
        deepest      = 0;
        burst_left   = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(make_row(OP_TAKE, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0, 0));
        plan.push_back(make_row(OP_READ, 0, 0, 1, 1, ST_RANGE, 0, 0, 0, 0));
        plan.push_back(make_row(OP_DELETE, 0, 1, 1, 1, ST_EMPTY, 0, 0, 0, 0));
        plan.push_back(make_row(OP_REVERSE, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0, 0));
        plan.push_back(make_row(OP_CLEAR, 0, 0, 1, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_SPARE_6, 0, 0, 1, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_SPARE_7, ALL_ONES, POS_W'(31), 1, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_APPEND, ALL_ONES, 0, 1, 1, ST_OK, 0, 1, ALL_ONES,
                                ALL_ONES));
        plan.push_back(make_row(OP_APPEND, 0, 0, 1, 1, ST_OK, 0, 2, ALL_ONES, 0));
        plan.push_back(make_row(OP_READ, 0, 1, 1, 1, ST_OK, ALL_ONES, 2, ALL_ONES, 0));
        plan.push_back(make_row(OP_READ, 0, 2, 1, 1, ST_OK, 0, 2, ALL_ONES, 0));
        plan.push_back(make_row(OP_READ, 0, 3, 1, 1, ST_RANGE, 0, 2, ALL_ONES, 0));
        plan.push_back(make_row(OP_DELETE, 0, 0, 1, 1, ST_RANGE, 0, 2, ALL_ONES, 0));
        plan.push_back(make_row(OP_APPEND, FILL_BASE, 0, DEPTH_DEF - 2, 0, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_APPEND, 32'hA5A5_A5A5, 0, 1, 1, ST_FULL, 0, DEPTH_DEF,
                                ALL_ONES, FILL_BASE + DEPTH_DEF - 3));
        plan.push_back(make_row(OP_READ, 0, POS_W'(DEPTH_DEF), 1, 0, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_READ, 0, POS_W'(DEPTH_DEF + 1), 1, 1, ST_RANGE, 0,
                                DEPTH_DEF, ALL_ONES, FILL_BASE + DEPTH_DEF - 3));
        plan.push_back(make_row(OP_READ, 0, POS_W'(31), 1, 1, ST_RANGE, 0, DEPTH_DEF,
                                ALL_ONES, FILL_BASE + DEPTH_DEF - 3));
        plan.push_back(make_row(OP_REVERSE, 0, 0, 1, 0, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_DELETE, 0, POS_W'(DEPTH_DEF), 1, 0, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_DELETE, 0, 1, 1, 0, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_DELETE, 0, 7, 1, 0, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_TAKE, 0, 0, 1, 0, ST_OK, 0, 0, 0, 0));
        plan.push_back(make_row(OP_CLEAR, 0, 0, 1, 1, ST_OK, 0, 0, 0, 0));

        foreach (plan[i]) begin
            row = plan[i];
            for (int k = 0; k < row.reps; k++) begin
                req = row.req;
                req.value = row.req.value + k;
                issue(req, row.pinned, row.want);
                pause(pick_gap());
            end
        end

        drain_results();

        fill_bias = 50;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: fill_bias = 30;
                    1: fill_bias = 50;
                    2: fill_bias = 70;
                    default: fill_bias = 90;
                endcase
            end
            if (n > 0 && n % 500 == 0) drain_results();

            if ($urandom_range(0, 99) < fill_bias) begin
                req.opcode = OP_APPEND;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 25) req.opcode = OP_TAKE;
                else if (r < 55) req.opcode = OP_READ;
                else if (r < 80) req.opcode = OP_DELETE;
                else if (r < 92) req.opcode = OP_REVERSE;
                else if (r < 96) req.opcode = OP_CLEAR;
                else if (r < 98) req.opcode = OP_SPARE_6;
                else req.opcode = OP_SPARE_7;
            end

            case ($urandom_range(0, 9))
                0: req.value = 0;
                1: req.value = ALL_ONES;
                default: req.value = $urandom;
            endcase

            r = $urandom_range(0, 9);
            if (r < 7) begin
                req.position = (shadow_count > 0) ? POS_W'($urandom_range(1, shadow_count))
                                                  : POS_W'(1);
            end
            else if (r == 7) req.position = '0;
            else if (r == 8) req.position = POS_W'(shadow_count + 1);
            else req.position = POS_W'($urandom_range(0, 31));

            issue(req, 1'b0, none);
            pause(pick_gap());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("queue run: %0d requests, %0d results; ok %0d, empty %0d, range %0d, full %0d",
                 accepted, results_seen, status_tally[ST_OK], status_tally[ST_EMPTY],
                 status_tally[ST_RANGE], status_tally[ST_FULL]);
        $display("deepest fill %0d of %0d entries, %0d mismatches", deepest, DEPTH_DEF,
                 mismatches);
        if (mismatches == 0 && pending_res.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
